FILE: rtl/core/tsig_pkg.sv
`timescale 1ns / 1ps

package tsig_pkg;

  // field widths
  localparam int MODE_W     = 1;
  localparam int DISTANCE_W = 24;
  localparam int TSPEED_W   = 16;
  localparam int ACCEL_W    = 20;
  localparam int MSPEED_W   = 16;
  localparam int TFREQ_W    = 28;
  localparam int SPEED_W    = 32;
  localparam int TICKS_W    = 32;
  localparam int SQ_W       = 2 * TSPEED_W;
  localparam int RAMP_NUM_W = SQ_W + 1;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

  // request codes
  localparam logic [MODE_W-1:0] MODE_LOAD = 1'b0;
  localparam logic [MODE_W-1:0] MODE_STEP = 1'b1;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TFREQ_W;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_FREQ = 1'b1;

  localparam logic [MSPEED_W-1:0] MIN_SPEED_RST  = 16'd100;
  localparam logic [TFREQ_W-1:0]  TIMER_FREQ_RST = 28'd1000000;

  typedef struct packed {
    logic load_move;
    logic ramp_start;
    logic ramp_load;
    logic set_min_speed;
    logic delta_start;
    logic speed_update;
    logic ticks_start;
    logic out_load;
  } tsig_cmd_t;

  typedef struct packed {
    logic step_ok;
    logic first_step;
    logic ramp_trivial;
    logic div_done;
  } tsig_stat_t;

endpackage

FILE: rtl/core/tsig_if.sv
`timescale 1ns / 1ps

interface tsig_in_if;
  import tsig_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [DISTANCE_W-1:0] distance;
  logic [TSPEED_W-1:0]   target_speed;
  logic [ACCEL_W-1:0]    accel_rate;
  logic                  direction;

  modport source (
    output valid, mode, distance, target_speed, accel_rate, direction,
    input  ready
  );
  modport sink (
    input  valid, mode, distance, target_speed, accel_rate, direction,
    output ready
  );
endinterface

interface tsig_out_if;
  import tsig_pkg::*;

  logic               valid;
  logic               ready;
  logic [TICKS_W-1:0] interval_ticks;
  logic               step_level;
  logic               dir_level;
  logic               last_step;

  modport source (
    output valid, interval_ticks, step_level, dir_level, last_step,
    input  ready
  );
  modport sink (
    input  valid, interval_ticks, step_level, dir_level, last_step,
    output ready
  );
endinterface

FILE: rtl/core/trapezoid_step_interval_generator.sv
`timescale 1ns / 1ps
// Load word: the ramp length takes one division on the shared bit-serial divider, none when
// the ramp length needs no division.
// Step word: two divisions, one for the first step of a move; the result is registered in
// ST_DONE, which waits while the output register is full and not draining, then goes idle.
// DIV_W is the widest of the delta, tick and ramp dividends (52 at FRAC_BITS = 16).
// Synchronous active-low reset: idle, no move, config back to 100 steps/s and 1 MHz.
module trapezoid_step_interval_generator #(
  parameter int DIST_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tsig_in_if.sink                         in_ch,
  tsig_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tsig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsig_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tsig_pkg::*;

  tsig_cmd_t  cmd;
  tsig_stat_t stat;

  tsig_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tsig_datapath #(
    .DIST_BITS (DIST_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_distance        (in_ch.distance),
    .in_target_speed    (in_ch.target_speed),
    .in_accel_rate      (in_ch.accel_rate),
    .in_direction       (in_ch.direction),
    .out_interval_ticks (out_ch.interval_ticks),
    .out_step_level     (out_ch.step_level),
    .out_dir_level      (out_ch.dir_level),
    .out_last_step      (out_ch.last_step)
  );

endmodule

FILE: rtl/core/tsig_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Quotient holds until next start.
module tsig_div #(
  parameter int DIV_W = 52
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DIV_W-1:0]             dividend,
  input  logic [tsig_pkg::SPEED_W-1:0] divisor,
  output logic [DIV_W-1:0]             quotient,
  output logic                         done
);
  import tsig_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [SPEED_W-1:0] rem_r;
  logic [SPEED_W-1:0] dvsr_r;
  logic [DIV_W-1:0]   dq_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [SPEED_W:0] sh;
  logic [SPEED_W:0] diff;
  logic             ge;

  always_comb begin
    sh   = {rem_r, dq_r[DIV_W-1]};
    diff = sh - {1'b0, dvsr_r};
    ge   = (sh >= {1'b0, dvsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      dvsr_r <= divisor;
      dq_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? diff[SPEED_W-1:0] : sh[SPEED_W-1:0];
      dq_r  <= {dq_r[DIV_W-2:0], ge};
    end
  end

  assign quotient = dq_r;
  assign done     = done_r;

endmodule

FILE: rtl/core/tsig_datapath.sv
`timescale 1ns / 1ps

module tsig_datapath #(
  parameter int DIST_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tsig_pkg::tsig_cmd_t             cmd,
  output tsig_pkg::tsig_stat_t            stat,
  input  logic                            cfg_we,
  input  logic [tsig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsig_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [tsig_pkg::DISTANCE_W-1:0] in_distance,
  input  logic [tsig_pkg::TSPEED_W-1:0]   in_target_speed,
  input  logic [tsig_pkg::ACCEL_W-1:0]    in_accel_rate,
  input  logic                            in_direction,
  output logic [tsig_pkg::TICKS_W-1:0]    out_interval_ticks,
  output logic                            out_step_level,
  output logic                            out_dir_level,
  output logic                            out_last_step
);
  import tsig_pkg::*;

  localparam int DELTA_W = ACCEL_W + 2 * FRAC_BITS;
  localparam int TICK_W  = TFREQ_W + FRAC_BITS;
  localparam int DW_A    = (DELTA_W > TICK_W) ? DELTA_W : TICK_W;
  localparam int DIV_W   = (DW_A > RAMP_NUM_W) ? DW_A : RAMP_NUM_W;
  localparam int MQ_W    = MSPEED_W + FRAC_BITS;

  // configuration
  logic [MSPEED_W-1:0] min_speed_r;
  logic [TFREQ_W-1:0]  timer_freq_r;

  // move state
  logic                 active_r;
  logic [DIST_BITS-1:0] step_count_r;
  logic [DIST_BITS-1:0] ramp_r;
  logic [DIST_BITS-1:0] length_r;
  logic [ACCEL_W-1:0]   accel_r;
  logic                 dir_r;
  logic [SPEED_W-1:0]   speed_r;
  logic                 phase_r;

  logic [TSPEED_W-1:0] tgt_r;
  logic [SQ_W-1:0]     sq_v_r;
  logic [SQ_W-1:0]     sq_m_r;

  logic [TICKS_W-1:0] ticks_r;
  logic               step_lvl_r;
  logic               dir_lvl_r;
  logic               last_r;

  logic [MSPEED_W-1:0]   vmin;
  logic [MQ_W-1:0]       mq_wide;
  logic [SPEED_W-1:0]    minq;
  logic [SPEED_W-1:0]    s_cur;
  logic [DIST_BITS-1:0]  half;
  logic                  ramp_trivial;
  logic [DIST_BITS-1:0]  ramp_triv_val;
  logic [RAMP_NUM_W-1:0] num;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [SPEED_W-1:0]    div_divisor;
  logic [DIV_W-1:0]      q;
  logic                  div_done;
  logic [DIST_BITS-1:0]  ramp_q;
  logic                  d_hi;
  logic [SPEED_W-1:0]    d_lo;
  logic [SPEED_W:0]      acc_sum;
  logic [SPEED_W-1:0]    acc_speed;
  logic [SPEED_W-1:0]    dec_raw;
  logic [SPEED_W-1:0]    dec_speed;
  logic [SPEED_W-1:0]    speed_nxt;
  logic [TICKS_W-1:0]    ticks_sat;
  logic [DIST_BITS-1:0]  count_inc;

  always_comb begin
    vmin    = (min_speed_r == '0) ? MSPEED_W'(1) : min_speed_r;
    mq_wide = {vmin, {FRAC_BITS{1'b0}}};
    minq    = (mq_wide > MQ_W'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(mq_wide);
    s_cur   = (speed_r < minq) ? minq : speed_r;

    half          = length_r >> 1;
    ramp_trivial  = (tgt_r <= vmin) || (accel_r == '0);
    ramp_triv_val = (tgt_r <= vmin) ? '0 : half;
    // round((v^2 - vmin^2) / 2a) as floor((v^2 - vmin^2 + a) / 2a), num holding v^2 - vmin^2 + a
    num = {1'b0, sq_v_r - sq_m_r} + RAMP_NUM_W'(accel_r);

    div_start = (cmd.ramp_start && !ramp_trivial) || cmd.delta_start || cmd.ticks_start;
    priority if (cmd.ramp_start) begin
      div_dividend = DIV_W'(num);
      div_divisor  = SPEED_W'({accel_r, 1'b0});
    end else if (cmd.delta_start) begin
      div_dividend = DIV_W'({accel_r, {(2 * FRAC_BITS){1'b0}}});
      div_divisor  = s_cur;
    end else begin
      div_dividend = DIV_W'({timer_freq_r, {FRAC_BITS{1'b0}}});
      div_divisor  = speed_r;
    end

    ramp_q = (q > DIV_W'(half)) ? half : DIST_BITS'(q);

    d_hi      = |q[DIV_W-1:SPEED_W];
    d_lo      = q[SPEED_W-1:0];
    acc_sum   = {1'b0, s_cur} + {1'b0, d_lo};
    acc_speed = (d_hi || acc_sum[SPEED_W]) ? SPEED_MAX : acc_sum[SPEED_W-1:0];
    dec_raw   = (d_hi || (d_lo >= s_cur)) ? '0 : (s_cur - d_lo);
    dec_speed = (dec_raw < minq) ? minq : dec_raw;

    priority if (step_count_r <= ramp_r) begin
      speed_nxt = acc_speed;
    end else if (step_count_r >= (length_r - ramp_r)) begin
      speed_nxt = dec_speed;
    end else begin
      speed_nxt = s_cur;
    end

    ticks_sat = (|q[DIV_W-1:TICKS_W]) ? TICKS_MAX : q[TICKS_W-1:0];
    count_inc = step_count_r + DIST_BITS'(1);
  end

  tsig_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (q),
    .done     (div_done)
  );

  always_comb begin
    stat.step_ok      = active_r && (step_count_r < length_r);
    stat.first_step   = (step_count_r == '0);
    stat.ramp_trivial = ramp_trivial;
    stat.div_done     = div_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r  <= MIN_SPEED_RST;
      timer_freq_r <= TIMER_FREQ_RST;
      active_r     <= 1'b0;
      step_count_r <= '0;
      ramp_r       <= '0;
      length_r     <= '0;
      accel_r      <= '0;
      dir_r        <= 1'b0;
      speed_r      <= '0;
      phase_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_SPEED:  min_speed_r  <= cfg_wdata[MSPEED_W-1:0];
          CFG_TIMER_FREQ: timer_freq_r <= cfg_wdata[TFREQ_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_move) begin
        length_r     <= DIST_BITS'(in_distance);
        accel_r      <= in_accel_rate;
        dir_r        <= in_direction;
        step_count_r <= '0;
        speed_r      <= '0;
        active_r     <= (DIST_BITS'(in_distance) != '0);
      end
      if (cmd.ramp_start && ramp_trivial) begin
        ramp_r <= ramp_triv_val;
      end
      if (cmd.ramp_load) begin
        ramp_r <= ramp_q;
      end
      if (cmd.set_min_speed) begin
        speed_r <= minq;
      end
      if (cmd.speed_update) begin
        speed_r <= speed_nxt;
      end
      if (cmd.out_load) begin
        step_count_r <= count_inc;
        phase_r      <= ~phase_r;
        if (count_inc == length_r) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_move) begin
      tgt_r <= in_target_speed;
    end
    sq_v_r <= SQ_W'(tgt_r) * SQ_W'(tgt_r);
    sq_m_r <= SQ_W'(vmin) * SQ_W'(vmin);
    if (cmd.out_load) begin
      ticks_r    <= ticks_sat;
      step_lvl_r <= ~phase_r;
      dir_lvl_r  <= dir_r;
      last_r     <= (count_inc == length_r);
    end
  end

  assign out_interval_ticks = ticks_r;
  assign out_step_level     = step_lvl_r;
  assign out_dir_level      = dir_lvl_r;
  assign out_last_step      = last_r;

endmodule

FILE: rtl/core/tsig_ctrl.sv
`timescale 1ns / 1ps

module tsig_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [tsig_pkg::MODE_W-1:0]        in_mode,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tsig_pkg::tsig_cmd_t                cmd,
  input  tsig_pkg::tsig_stat_t               stat
);
  import tsig_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_RAMP,
    ST_RAMP_WAIT,
    ST_DELTA,
    ST_DELTA_WAIT,
    ST_TICKS,
    ST_TICKS_WAIT,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load_move = 1'b1;
            state_nxt     = ST_SQ;
          end else if (stat.step_ok) begin
            if (stat.first_step) begin
              cmd.set_min_speed = 1'b1;
              state_nxt         = ST_TICKS;
            end else begin
              state_nxt = ST_DELTA;
            end
          end
        end
      end
      ST_SQ: state_nxt = ST_RAMP;
      ST_RAMP: begin
        cmd.ramp_start = 1'b1;
        state_nxt      = stat.ramp_trivial ? ST_IDLE : ST_RAMP_WAIT;
      end
      ST_RAMP_WAIT: begin
        if (stat.div_done) begin
          cmd.ramp_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DELTA: begin
        cmd.delta_start = 1'b1;
        state_nxt       = ST_DELTA_WAIT;
      end
      ST_DELTA_WAIT: begin
        if (stat.div_done) begin
          cmd.speed_update = 1'b1;
          state_nxt        = ST_TICKS;
        end
      end
      ST_TICKS: begin
        cmd.ticks_start = 1'b1;
        state_nxt       = ST_TICKS_WAIT;
      end
      ST_TICKS_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // output word register must be free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
